### rtl/bse_pkg.sv
// Shared types and constants for the bucket sort engine.
package bse_pkg;

    localparam int DATA_BITS = 13;
    localparam int BB_BITS = 3;
    localparam logic [BB_BITS-1:0] BB_RESET = 3'd3;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [DATA_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] sorted_value;
        logic                 valid_res;
        logic                 last;
        logic [1:0]           status;
    } res_t;

endpackage

### rtl/bucket_sort_engine.sv
// Top level of the bucket sort engine: request sequencer around the store and fill memories.
//
// A request word (req_valid/req_ready, payload req) is a load, a read or a clear.
// Every request yields exactly one result word on res_valid/res_ready (payload res).
// The config channel (cfg_valid/cfg_ready, cfg_data) sets bucket_bits and empties
// all buckets; it is taken only between requests.
// A load passes through S_LD to S_RESP; a clear or an unused request code goes to S_RESP
// directly. A read passes through S_RD_CHK, S_RD_EVAL (again for each empty bucket
// skipped) and S_RD_DATA, or goes to S_RESP early when nothing is left to read.
// S_RESP moves the result into the output register, waiting while that is full;
// the sequencer then returns to S_IDLE to take the next request.
// The first read after a load first sorts each bucket in place with an exchange
// sort over the store memory. S_SRT_N skips a bucket of fewer than two values; each
// outer pass loads a pivot in S_SRT_PIV, swaps smaller values in within S_SRT_CMP and
// writes the pivot back in S_SRT_WI. The store RAM has one read port and one write port.
// A new request is accepted while the previous result still waits in the output
// register; if the receiver stalls, the sequencer holds its next result until the
// output register frees up.
// Reset empties all buckets at once through per-bucket valid bits on the fill
// counts and sets bucket_bits to 3; no clearing pass is needed.
module bucket_sort_engine #(
    parameter int MAX_BUCKET_BITS = 6,
    parameter int BUCKET_DEPTH    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bse_pkg::req_t                req,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bse_pkg::res_t                res,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bse_pkg::BB_BITS-1:0]  cfg_data
);

    localparam int NSLOT = 1 << MAX_BUCKET_BITS;
    localparam int KW    = (MAX_BUCKET_BITS > 0) ? MAX_BUCKET_BITS : 1;
    localparam int NBW   = KW + 1;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int SD    = NSLOT * BUCKET_DEPTH;
    localparam int AW    = $clog2(SD);
    localparam int CW    = $clog2(SD + 1);
    localparam int DW    = bse_pkg::DATA_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD,
        S_SRT_N,
        S_SRT_PIV,
        S_SRT_CMP,
        S_SRT_WI,
        S_RD_CHK,
        S_RD_EVAL,
        S_RD_DATA,
        S_RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [bse_pkg::BB_BITS-1:0]  bb_reg, bb_next;
    logic [NSLOT-1:0]             fill_vld_reg, fill_vld_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [NBW-1:0]               rb_reg, rb_next;
    logic [FW-1:0]                rp_reg, rp_next;
    logic [CW-1:0]                rt_reg, rt_next;
    logic                         sorted_reg, sorted_next;
    logic [NBW-1:0]               b_reg, b_next;
    logic [FW-1:0]                n_reg, n_next;
    logic [FW-1:0]                i_reg, i_next;
    logic [FW-1:0]                j_reg, j_next;
    logic [DW-1:0]                piv_reg, piv_next;
    logic [DW-1:0]                val_reg, val_next;
    logic [KW-1:0]                k_reg, k_next;
    bse_pkg::res_t                res_reg, res_next;
    bse_pkg::res_t                out_reg, out_next;
    logic                         out_vld_reg, out_vld_next;
    logic [KW-1:0]                fill_raddr_q_reg;

    logic                         store_we;
    logic [AW-1:0]                store_waddr;
    logic [DW-1:0]                store_wdata;
    logic [AW-1:0]                store_raddr;
    logic [DW-1:0]                store_rdata;
    logic                         fill_we;
    logic [KW-1:0]                fill_waddr;
    logic [FW-1:0]                fill_wdata;
    logic [KW-1:0]                fill_raddr;
    logic [FW-1:0]                fill_rdata;
    logic [FW-1:0]                fill_eff;
    logic [2:0]                   eb;
    logic [NBW-1:0]               nb;
    logic [3:0]                   shamt;

    function automatic logic [AW-1:0] saddr(input logic [KW-1:0] k, input logic [FW-1:0] p);
        logic [AW-1:0] base;
        base = AW'(AW'(k) * AW'(BUCKET_DEPTH));
        return base + AW'(p);
    endfunction

    bse_ram #(.WIDTH(DW), .DEPTH(SD), .AW(AW)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    bse_ram #(.WIDTH(FW), .DEPTH(NSLOT), .AW(KW)) u_fill (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    assign eb = (32'(bb_reg) > MAX_BUCKET_BITS) ? 3'(MAX_BUCKET_BITS) : bb_reg;
    assign nb = NBW'(1) << eb;
    assign shamt = 4'(DW) - {1'b0, eb};
    assign fill_eff = fill_vld_reg[fill_raddr_q_reg] ? fill_rdata : '0;

    assign req_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign res_valid = out_vld_reg;
    assign res = out_reg;

    always_comb
    begin
        state_next    = state_reg;
        bb_next       = bb_reg;
        fill_vld_next = fill_vld_reg;
        count_next    = count_reg;
        rb_next       = rb_reg;
        rp_next       = rp_reg;
        rt_next       = rt_reg;
        sorted_next   = sorted_reg;
        b_next        = b_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        piv_next      = piv_reg;
        val_next      = val_reg;
        k_next        = k_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !res_ready;
        store_we      = 1'b0;
        store_waddr   = '0;
        store_wdata   = '0;
        store_raddr   = '0;
        fill_we       = 1'b0;
        fill_waddr    = '0;
        fill_wdata    = '0;
        fill_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    bb_next       = cfg_data;
                    fill_vld_next = '0;
                    count_next    = '0;
                    rb_next       = '0;
                    rp_next       = '0;
                    rt_next       = '0;
                    sorted_next   = 1'b0;
                end
                else if (req_valid)
                begin
                    res_next = '0;
                    case (req.req_type)
                        bse_pkg::REQ_LOAD:
                        begin
                            val_next   = req.value;
                            k_next     = KW'(req.value >> shamt);
                            fill_raddr = KW'(req.value >> shamt);
                            state_next = S_LD;
                        end
                        bse_pkg::REQ_READ:
                        begin
                            if (!sorted_reg)
                            begin
                                sorted_next = 1'b1;
                                rb_next     = '0;
                                rp_next     = '0;
                                rt_next     = '0;
                                b_next      = '0;
                                fill_raddr  = '0;
                                state_next  = S_SRT_N;
                            end
                            else
                            begin
                                state_next = S_RD_CHK;
                            end
                        end
                        bse_pkg::REQ_CLEAR:
                        begin
                            fill_vld_next = '0;
                            count_next    = '0;
                            rb_next       = '0;
                            rp_next       = '0;
                            rt_next       = '0;
                            sorted_next   = 1'b0;
                            state_next    = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_LD:
            begin
                if (fill_eff >= FW'(BUCKET_DEPTH))
                begin
                    res_next.status = bse_pkg::ST_FULL;
                end
                else
                begin
                    store_we              = 1'b1;
                    store_waddr           = saddr(k_reg, fill_eff);
                    store_wdata           = val_reg;
                    fill_we               = 1'b1;
                    fill_waddr            = k_reg;
                    fill_wdata            = fill_eff + 1'b1;
                    fill_vld_next[k_reg]  = 1'b1;
                    count_next            = count_reg + 1'b1;
                    sorted_next           = 1'b0;
                end
                state_next = S_RESP;
            end
            S_SRT_N:
            begin
                n_next = fill_eff;
                if (fill_eff < FW'(2))
                begin
                    if (NBW'(b_reg + 1'b1) == nb)
                    begin
                        state_next = S_RD_CHK;
                    end
                    else
                    begin
                        b_next     = b_reg + 1'b1;
                        fill_raddr = KW'(b_reg + 1'b1);
                    end
                end
                else
                begin
                    i_next      = '0;
                    store_raddr = saddr(KW'(b_reg), '0);
                    state_next  = S_SRT_PIV;
                end
            end
            S_SRT_PIV:
            begin
                piv_next    = store_rdata;
                j_next      = i_reg + 1'b1;
                store_raddr = saddr(KW'(b_reg), FW'(i_reg + 1'b1));
                state_next  = S_SRT_CMP;
            end
            S_SRT_CMP:
            begin
                if (store_rdata < piv_reg)
                begin
                    store_we    = 1'b1;
                    store_waddr = saddr(KW'(b_reg), j_reg);
                    store_wdata = piv_reg;
                    piv_next    = store_rdata;
                end
                if (FW'(j_reg + 1'b1) < n_reg)
                begin
                    j_next      = j_reg + 1'b1;
                    store_raddr = saddr(KW'(b_reg), FW'(j_reg + 1'b1));
                end
                else
                begin
                    state_next = S_SRT_WI;
                end
            end
            S_SRT_WI:
            begin
                store_we    = 1'b1;
                store_waddr = saddr(KW'(b_reg), i_reg);
                store_wdata = piv_reg;
                if (FW'(i_reg + 2'd2) < n_reg)
                begin
                    i_next      = i_reg + 1'b1;
                    store_raddr = saddr(KW'(b_reg), FW'(i_reg + 1'b1));
                    state_next  = S_SRT_PIV;
                end
                else if (NBW'(b_reg + 1'b1) == nb)
                begin
                    state_next = S_RD_CHK;
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    fill_raddr = KW'(b_reg + 1'b1);
                    state_next = S_SRT_N;
                end
            end
            S_RD_CHK:
            begin
                if (rt_reg >= count_reg)
                begin
                    res_next.status = bse_pkg::ST_EMPTY;
                    state_next      = S_RESP;
                end
                else
                begin
                    fill_raddr = KW'(rb_reg);
                    state_next = S_RD_EVAL;
                end
            end
            S_RD_EVAL:
            begin
                if (rp_reg >= fill_eff)
                begin
                    if (NBW'(rb_reg + 1'b1) >= nb)
                    begin
                        res_next.status = bse_pkg::ST_EMPTY;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        rb_next    = rb_reg + 1'b1;
                        rp_next    = '0;
                        fill_raddr = KW'(rb_reg + 1'b1);
                    end
                end
                else
                begin
                    store_raddr = saddr(KW'(rb_reg), rp_reg);
                    state_next  = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                res_next.sorted_value = store_rdata;
                res_next.valid_res    = 1'b1;
                res_next.last         = (CW'(rt_reg + 1'b1) == count_reg);
                res_next.status       = bse_pkg::ST_OK;
                rp_next               = rp_reg + 1'b1;
                rt_next               = rt_reg + 1'b1;
                state_next            = S_RESP;
            end
            S_RESP:
            begin
                if (!out_vld_reg || res_ready)
                begin
                    out_vld_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bb_reg       <= bse_pkg::BB_RESET;
            fill_vld_reg <= '0;
            count_reg    <= '0;
            rb_reg       <= '0;
            rp_reg       <= '0;
            rt_reg       <= '0;
            sorted_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bb_reg       <= bb_next;
            fill_vld_reg <= fill_vld_next;
            count_reg    <= count_next;
            rb_reg       <= rb_next;
            rp_reg       <= rp_next;
            rt_reg       <= rt_next;
            sorted_reg   <= sorted_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg            <= b_next;
        n_reg            <= n_next;
        i_reg            <= i_next;
        j_reg            <= j_next;
        piv_reg          <= piv_next;
        val_reg          <= val_next;
        k_reg            <= k_next;
        res_reg          <= res_next;
        out_reg          <= out_next;
        fill_raddr_q_reg <= fill_raddr;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> fill_wdata <= FW'(BUCKET_DEPTH))
        else $error("fill count written beyond bucket depth");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rt_reg <= count_reg)
        else $error("read total exceeds stored count");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> res.valid_res)
        else $error("last flagged on a result without a value");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.valid_res |-> res.status == bse_pkg::ST_OK)
        else $error("value returned with a non-ok status");

    a_store_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> state_reg == S_LD || state_reg == S_SRT_CMP || state_reg == S_SRT_WI)
        else $error("store written outside load or sort");

endmodule

### rtl/bse_ram.sv
// Simple dual-port synchronous RAM with a registered read.
module bse_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### tb/sv/bucket_sort_engine_test.sv
// Self-checking testbench for the bucket sort engine: loads, sorted reads, clears, settings.
module bucket_sort_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BINS = 64;
    localparam int BIN_DEPTH = 64;
    localparam int MAX_BINS_LOG = 6;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    bse_pkg::req_t req;
    logic res_valid;
    logic res_ready;
    bse_pkg::res_t res;
    logic cfg_valid;
    logic cfg_ready;
    logic [bse_pkg::BB_BITS-1:0] cfg_data;

    bucket_sort_engine u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    logic [bse_pkg::DATA_BITS-1:0] bin_vals [NUM_BINS][BIN_DEPTH];
    int bin_fill [NUM_BINS];
    int stored_total;
    int read_bin;
    int read_pos;
    int read_done;
    bit bins_sorted;
    logic [bse_pkg::BB_BITS-1:0] bin_bits;

    bse_pkg::res_t expected_words [$];
    int errors;
    int words_sent;
    int words_checked;
    int overflows_seen;
    int idle_cycles;
    int burst_left;
    int hold_cycles;
    bit stall_mode;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int bins_log();
        return (bin_bits > MAX_BINS_LOG) ? MAX_BINS_LOG : int'(bin_bits);
    endfunction

    function automatic void empty_bins();
        for (int k = 0; k < NUM_BINS; k++)
            bin_fill[k] = 0;
        stored_total = 0;
        read_bin = 0;
        read_pos = 0;
        read_done = 0;
        bins_sorted = 1'b0;
    endfunction

    function automatic bse_pkg::res_t sort_predict(bse_pkg::req_t w);
        bse_pkg::res_t r;
        int nb;
        int k;
        logic [bse_pkg::DATA_BITS-1:0] t;
        r = '0;
        nb = 1 << bins_log();
        if (w.req_type == bse_pkg::REQ_LOAD)
        begin
            k = int'(w.value >> (bse_pkg::DATA_BITS - bins_log())) & (NUM_BINS - 1);
            if (bin_fill[k] >= BIN_DEPTH)
            begin
                r.status = bse_pkg::ST_FULL;
            end
            else
            begin
                bin_vals[k][bin_fill[k]] = w.value;
                bin_fill[k]++;
                stored_total++;
                bins_sorted = 1'b0;
            end
        end
        else if (w.req_type == bse_pkg::REQ_READ)
        begin
            if (!bins_sorted)
            begin
                for (int b = 0; b < nb; b++)
                    for (int i = 0; i < bin_fill[b]; i++)
                        for (int j = i + 1; j < bin_fill[b]; j++)
                            if (bin_vals[b][i] > bin_vals[b][j])
                            begin
                                t = bin_vals[b][i];
                                bin_vals[b][i] = bin_vals[b][j];
                                bin_vals[b][j] = t;
                            end
                bins_sorted = 1'b1;
                read_bin = 0;
                read_pos = 0;
                read_done = 0;
            end
            while (read_bin < nb && read_pos >= bin_fill[read_bin])
            begin
                read_bin++;
                read_pos = 0;
            end
            if (read_done >= stored_total || read_bin >= nb)
            begin
                r.status = bse_pkg::ST_EMPTY;
            end
            else
            begin
                r.sorted_value = bin_vals[read_bin][read_pos];
                r.valid_res = 1'b1;
                read_pos++;
                read_done++;
                r.last = (read_done == stored_total);
            end
        end
        else if (w.req_type == bse_pkg::REQ_CLEAR)
        begin
            empty_bins();
        end
        return r;
    endfunction

    // The receiver stalls on its own pattern, or holds off entirely for hold_cycles.
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ready = 1'b0;
                hold_cycles--;
            end
            else
            begin
                res_ready = stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        bse_pkg::res_t e;
        if (rst_n && res_valid && res_ready)
        begin
            words_checked++;
            if (expected_words.size() == 0)
            begin
                $error("result word with no request outstanding");
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (res.sorted_value !== e.sorted_value)
                begin
                    $error("sorted_value: expected %0d, got %0d", e.sorted_value,
                        res.sorted_value);
                    errors++;
                end
                if (res.valid_res !== e.valid_res)
                begin
                    $error("valid_res: expected %0d, got %0d", e.valid_res, res.valid_res);
                    errors++;
                end
                if (res.last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, res.last);
                    errors++;
                end
                if (res.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, res.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(bse_pkg::req_t w, bit gaps);
        bse_pkg::res_t r;
        @(negedge clk);
        req_valid = 1'b1;
        req = w;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        r = sort_predict(w);
        if (r.status == bse_pkg::ST_FULL)
            overflows_seen++;
        expected_words.push_back(r);
        words_sent++;
        if (gaps)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(0, 12);
                @(negedge clk);
                req_valid = 1'b0;
                repeat ($urandom_range(0, 6))
                    @(negedge clk);
            end
        end
    endtask

    task automatic send_op(logic [1:0] op, logic [bse_pkg::DATA_BITS-1:0] v, bit gaps = 1'b0);
        bse_pkg::req_t w;
        w.req_type = op;
        w.value = v;
        send_word(w, gaps);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
    endtask

    task automatic write_bin_bits(logic [bse_pkg::BB_BITS-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        bin_bits = v;
        empty_bins();
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data = bse_pkg::BB_BITS'($urandom());
    endtask

    task automatic test_directed();
        send_op(bse_pkg::REQ_READ, 13'd0);
        send_op(bse_pkg::REQ_LOAD, 13'h1FFF);
        send_op(bse_pkg::REQ_LOAD, 13'd0);
        send_op(bse_pkg::REQ_LOAD, 13'h1000);
        send_op(bse_pkg::REQ_LOAD, 13'h0FFF);
        send_op(bse_pkg::REQ_LOAD, 13'h1555);
        send_op(bse_pkg::REQ_LOAD, 13'h0AAA);
        send_op(bse_pkg::REQ_LOAD, 13'h1FFE);
        send_op(REQ_UNUSED, 13'h1FFF);
        repeat (4)
            send_op(bse_pkg::REQ_READ, 13'h1FFF);
        send_op(bse_pkg::REQ_LOAD, 13'd1);
        repeat (9)
            send_op(bse_pkg::REQ_READ, 13'd0);
        send_op(bse_pkg::REQ_CLEAR, 13'h1ABC);
        send_op(bse_pkg::REQ_READ, 13'd0);
        drain();
    endtask

    task automatic fill_and_read(int loads, int reads, bit gaps);
        for (int i = 0; i < loads; i++)
            send_op(bse_pkg::REQ_LOAD, 13'($urandom()), gaps);
        for (int i = 0; i < reads; i++)
            send_op(bse_pkg::REQ_READ, 13'($urandom()), gaps);
    endtask

    task automatic test_bin_bits_sweep();
        for (int b = 0; b < 8; b++)
        begin
            write_bin_bits(bse_pkg::BB_BITS'(b));
            fill_and_read(12, 14, 1'b1);
        end
        write_bin_bits(3'd6);
        fill_and_read(8, 4, 1'b0);
        write_bin_bits(3'd0);
        fill_and_read(6, 8, 1'b0);
    endtask

    task automatic test_overflow();
        write_bin_bits(3'd3);
        for (int i = 0; i < BIN_DEPTH + 3; i++)
            send_op(bse_pkg::REQ_LOAD, {3'd5, 10'($urandom())}, 1'b1);
        repeat (4)
            send_op(bse_pkg::REQ_READ, 13'd0, 1'b1);
        send_op(bse_pkg::REQ_CLEAR, 13'd0);
    endtask

    task automatic test_backpressure();
        drain();
        hold_cycles = 300;
        fill_and_read(20, 20, 1'b0);
        send_op(bse_pkg::REQ_CLEAR, 13'd0);
        drain();
    endtask

    task automatic test_random(int count);
        int sent;
        int n;
        int extra;
        sent = 0;
        stall_mode = 1'b1;
        while (sent < count)
        begin
            n = $urandom_range(1, 30);
            case ($urandom_range(0, 9))
                0:
                begin
                    send_op(2'($urandom()), 13'($urandom()), 1'b1);
                    sent++;
                end
                1:
                begin
                    send_op(bse_pkg::REQ_CLEAR, 13'($urandom()), 1'b1);
                    sent++;
                end
                2:
                begin
                    fill_and_read(n / 2, n / 4, 1'b1);
                    fill_and_read(2, n, 1'b1);
                    sent += n / 2 + n / 4 + 2 + n;
                end
                default:
                begin
                    extra = $urandom_range(0, 2);
                    fill_and_read(n, n + extra, 1'b1);
                    sent += 2 * n + extra;
                end
            endcase
            if (stored_total > 120 || $urandom_range(0, 3) == 0)
            begin
                send_op(bse_pkg::REQ_CLEAR, 13'd0, 1'b1);
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                drain();
        end
        stall_mode = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        overflows_seen = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_cycles = 0;
        stall_mode = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        bin_bits = bse_pkg::BB_RESET;
        empty_bins();
        rst_n = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_bin_bits_sweep();
        test_overflow();
        test_backpressure();
        write_bin_bits(3'd4);
        test_random(100);
        write_bin_bits(3'd7);
        test_random(30);
        drain();

        $display("Sent %0d request words and checked %0d result words, %0d overflows,",
            words_sent, words_checked, overflows_seen);
        $display("across bucket_bits 0 to 7 with receiver stalls and a long hold-off.");
        if (errors == 0 && expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### bucket_sort_engine.f
rtl/bse_pkg.sv
rtl/bse_ram.sv
rtl/bucket_sort_engine.sv
tb/sv/bucket_sort_engine_test.sv
